FILE: rtl/cmls_pkg.sv
// Shared types, widths and codes of the colour map sampler.
// Used by the sampler core, the stop memory and the port checker.
`default_nettype none

package cmls_pkg;

  localparam int MAX_STOPS_DEF = 256;
  localparam int CH_W          = 8;
  localparam int POS_W         = 18;
  localparam int FRAC_W        = 16;
  localparam int CPOS_W        = FRAC_W + 1;        // clamped position 0..65536
  localparam int CNT_W         = 9;                 // stops_in_use width
  localparam int SCALED_W      = CPOS_W + CNT_W;    // clamped position * (stops - 1)
  localparam int IDX_W         = SCALED_W - FRAC_W;
  localparam int IDXSEL_W      = IDX_W - 1;         // stop index after the end check
  localparam int SEL_W         = 8;                 // stop_index field width
  localparam int DATA_W        = 32;
  localparam int PADDR_W       = 3;

  localparam logic [CNT_W-1:0] STOPS_RESET = CNT_W'(2);

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_WRITE  = 1'b1
  } action_t;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_STOPS_IN_USE = 1'b0,
    REG_NONE         = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  // low byte of floor((c2 - c1) * frac / 65536); the sum with c1 never leaves 0..255
  function automatic logic [CH_W-1:0] chan_delta(input logic [CH_W-1:0]   c1,
                                                 input logic [CH_W-1:0]   c2,
                                                 input logic [FRAC_W-1:0] frac);
    logic signed [CH_W:0]          diff;
    logic signed [CH_W+FRAC_W+1:0] prod;
    diff = $signed({1'b0, c2}) - $signed({1'b0, c1});
    prod = diff * $signed({1'b0, frac});
    return prod[FRAC_W+CH_W-1:FRAC_W];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/cmls_stop_ram.sv
// Colour stop memory: one write port, two registered read ports.
// Depends on cmls_pkg for the stop colour type.
`default_nettype none

module cmls_stop_ram #(
  parameter  int DEPTH = cmls_pkg::MAX_STOPS_DEF,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire              clk,
  input  wire              wr_en,
  input  wire [AW-1:0]     wr_addr,
  input  cmls_pkg::rgb_t   wr_data,
  input  wire              rd_en,
  input  wire [AW-1:0]     rd_addr_a,
  input  wire [AW-1:0]     rd_addr_b,
  output cmls_pkg::rgb_t   rd_data_a,
  output cmls_pkg::rgb_t   rd_data_b
);

  cmls_pkg::rgb_t mem [DEPTH];
  cmls_pkg::rgb_t rd_a_r;
  cmls_pkg::rgb_t rd_b_r;

  // read returns the old contents on a same-edge write to the same entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_a_r <= mem[rd_addr_a];
      rd_b_r <= mem[rd_addr_b];
    end
  end

  assign rd_data_a = rd_a_r;
  assign rd_data_b = rd_b_r;

endmodule

`default_nettype wire

FILE: rtl/colormap_lerp_sampler_core.sv
// Piecewise-linear colour map sampler: top level with pipeline and APB register.
// Depends on cmls_pkg and cmls_stop_ram.
//
// Usage:
//   Input channel (in_valid/in_ready): a beat with in_action = write stores one
//   colour stop at in_stop_index and gives no result; a beat with in_action =
//   sample clamps in_position (signed Q1.16) to 0..1, scales it by
//   stops_in_use - 1 and blends the two neighbouring stops.
//   Output channel (out_valid/out_ready): one beat per sample, in order.
//   APB port: one register at byte address 0, stops_in_use (9 bits, reset 2);
//   write it only while the block is idle.
//   Pipeline: a sample passes the scale multiply, the stop memory read, the
//   blend multiply and then the output register before its result is shown.
//   Throughput: one beat per cycle while the output is not stalled, set by the
//   single dual-read stop memory that every sample reads once.
//   Stall: when the output holds a beat that is not taken, the whole pipeline
//   holds and in_ready drops; in_ready stays high while the output register
//   is empty or being drained.
//   Reset clears the pipeline valids and the register; the stop memory is not
//   cleared, and stops must be written before they are sampled.
`default_nettype none

module colormap_lerp_sampler_core #(
  parameter int MAX_STOPS = cmls_pkg::MAX_STOPS_DEF
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // input channel
  input  wire                                in_valid,
  output logic                               in_ready,
  input  wire                                in_action,
  input  wire signed [cmls_pkg::POS_W-1:0]   in_position,
  input  wire [cmls_pkg::SEL_W-1:0]          in_stop_index,
  input  wire [cmls_pkg::CH_W-1:0]           in_stop_red,
  input  wire [cmls_pkg::CH_W-1:0]           in_stop_green,
  input  wire [cmls_pkg::CH_W-1:0]           in_stop_blue,
  // result channel
  output logic                               out_valid,
  input  wire                                out_ready,
  output logic [cmls_pkg::CH_W-1:0]          out_red,
  output logic [cmls_pkg::CH_W-1:0]          out_green,
  output logic [cmls_pkg::CH_W-1:0]          out_blue,
  // configuration
  input  wire                                cfg_psel,
  input  wire                                cfg_penable,
  input  wire                                cfg_pwrite,
  input  wire [cmls_pkg::PADDR_W-1:0]        cfg_paddr,
  input  wire [cmls_pkg::DATA_W-1:0]         cfg_pwdata,
  output logic [cmls_pkg::DATA_W-1:0]        cfg_prdata,
  output logic                               cfg_pready
);

  localparam int AW = $clog2(MAX_STOPS);
  localparam int CW = cmls_pkg::CH_W;
  localparam int FW = cmls_pkg::FRAC_W;

  // ---------------------------------------------------------------- register
  logic [cmls_pkg::CNT_W-1:0] stops_in_use_r, stops_in_use_nxt;
  logic [cmls_pkg::CNT_W-1:0] nm1_r, nm1_nxt;
  logic [cmls_pkg::CNT_W-1:0] wr_val;
  logic [cmls_pkg::CNT_W-1:0] n_eff;
  logic                       cfg_wr;
  logic                       cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit    = (cfg_paddr[2] == cmls_pkg::REG_STOPS_IN_USE);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit;
  assign wr_val     = cfg_pwdata[cmls_pkg::CNT_W-1:0];

  always_comb begin
    // zero means one stop; saturate at the memory depth
    n_eff = wr_val;
    if (wr_val == '0) begin
      n_eff = cmls_pkg::CNT_W'(1);
    end else if (32'(wr_val) > 32'(MAX_STOPS)) begin
      n_eff = cmls_pkg::CNT_W'(MAX_STOPS);
    end
    stops_in_use_nxt = stops_in_use_r;
    nm1_nxt          = nm1_r;
    if (cfg_wr) begin
      stops_in_use_nxt = wr_val;
      nm1_nxt          = n_eff - cmls_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stops_in_use_r <= cmls_pkg::STOPS_RESET;
      nm1_r          <= cmls_pkg::STOPS_RESET - cmls_pkg::CNT_W'(1);
    end else begin
      stops_in_use_r <= stops_in_use_nxt;
      nm1_r          <= nm1_nxt;
    end
  end

  assign cfg_prdata = cfg_hit ? cmls_pkg::DATA_W'(stops_in_use_r) : '0;

  // ---------------------------------------------------------------- pipeline control
  logic adv;
  logic in_acc;
  logic s1_valid_r, s2_valid_r, s3_valid_r, out_valid_r;
  logic s1_valid_nxt, s2_valid_nxt, s3_valid_nxt, out_valid_nxt;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;
  assign in_acc   = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    s2_valid_nxt  = s2_valid_r;
    s3_valid_nxt  = s3_valid_r;
    out_valid_nxt = out_valid_r;
    if (adv) begin
      s1_valid_nxt  = in_acc && (in_action == cmls_pkg::ACT_SAMPLE);
      s2_valid_nxt  = s1_valid_r;
      s3_valid_nxt  = s2_valid_r;
      out_valid_nxt = s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      s2_valid_r  <= s2_valid_nxt;
      s3_valid_r  <= s3_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // ---------------------------------------------------------------- stage 0: clamp, scale
  logic [cmls_pkg::CPOS_W-1:0]   pos_cl;
  logic [cmls_pkg::SCALED_W-1:0] scaled;
  logic [cmls_pkg::SCALED_W-1:0] s1_scaled_r;

  always_comb begin
    if (in_position[cmls_pkg::POS_W-1]) begin
      pos_cl = '0;
    end else if (in_position[FW] && (in_position[FW-1:0] != '0)) begin
      pos_cl = {1'b1, {FW{1'b0}}};
    end else begin
      pos_cl = in_position[cmls_pkg::CPOS_W-1:0];
    end
    scaled = cmls_pkg::SCALED_W'(pos_cl) * cmls_pkg::SCALED_W'(nm1_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_scaled_r <= scaled;
    end
  end

  // ---------------------------------------------------------------- stage 1: stop select, read
  logic [cmls_pkg::IDX_W-1:0]    s1_idx;
  logic                          s1_last;
  logic [cmls_pkg::IDXSEL_W-1:0] sel_a;
  logic [cmls_pkg::IDX_W-1:0]    sel_b;
  logic [FW-1:0]                 s2_frac_r;
  logic                          wr_en;
  cmls_pkg::rgb_t                wr_rgb;
  cmls_pkg::rgb_t                stop_a, stop_b;

  assign s1_idx  = s1_scaled_r[cmls_pkg::SCALED_W-1:FW];
  assign s1_last = (s1_idx >= {1'b0, nm1_r});
  assign sel_a   = s1_last ? nm1_r : s1_idx[cmls_pkg::IDXSEL_W-1:0];
  // at the last stop read stop a on both ports, the entry past it may be unwritten
  assign sel_b   = s1_last ? {1'b0, sel_a} : ({1'b0, sel_a} + cmls_pkg::IDX_W'(1));

  // write lands at its own accept edge, so a later sample always sees it
  assign wr_en        = in_acc && (in_action == cmls_pkg::ACT_WRITE) &&
                        (32'(in_stop_index) < 32'(MAX_STOPS));
  assign wr_rgb.red   = in_stop_red;
  assign wr_rgb.green = in_stop_green;
  assign wr_rgb.blue  = in_stop_blue;

  cmls_stop_ram #(
    .DEPTH (MAX_STOPS)
  ) u_stop_ram (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (AW'(in_stop_index)),
    .wr_data   (wr_rgb),
    .rd_en     (adv),
    .rd_addr_a (AW'(sel_a)),
    .rd_addr_b (AW'(sel_b)),
    .rd_data_a (stop_a),
    .rd_data_b (stop_b)
  );

  // at or past the last stop the fraction is dropped, so the blend returns stop a
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_frac_r <= s1_last ? '0 : s1_scaled_r[FW-1:0];
    end
  end

  // ---------------------------------------------------------------- stage 2: blend multiply
  cmls_pkg::rgb_t s3_base_r;
  cmls_pkg::rgb_t s3_delta_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_base_r        <= stop_a;
      s3_delta_r.red   <= cmls_pkg::chan_delta(stop_a.red,   stop_b.red,   s2_frac_r);
      s3_delta_r.green <= cmls_pkg::chan_delta(stop_a.green, stop_b.green, s2_frac_r);
      s3_delta_r.blue  <= cmls_pkg::chan_delta(stop_a.blue,  stop_b.blue,  s2_frac_r);
    end
  end

  // ---------------------------------------------------------------- stage 3: sum, output register
  cmls_pkg::rgb_t out_rgb_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      out_rgb_r.red   <= CW'(s3_base_r.red   + s3_delta_r.red);
      out_rgb_r.green <= CW'(s3_base_r.green + s3_delta_r.green);
      out_rgb_r.blue  <= CW'(s3_base_r.blue  + s3_delta_r.blue);
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_rgb_r.red;
  assign out_green = out_rgb_r.green;
  assign out_blue  = out_rgb_r.blue;

endmodule

`default_nettype wire

FILE: rtl/cmls_checker.sv
// Port-level checks for the colour map sampler, bound to the top level.
// Depends on cmls_pkg for field widths.
`default_nettype none

module cmls_checker (
  input wire                          clk,
  input wire                          rst_n,
  input wire                          in_ready,
  input wire                          out_valid,
  input wire                          out_ready,
  input wire [cmls_pkg::CH_W-1:0]     out_red,
  input wire [cmls_pkg::CH_W-1:0]     out_green,
  input wire [cmls_pkg::CH_W-1:0]     out_blue,
  input wire                          cfg_pready
);

  // reset empties the output
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // input is never blocked while the output register is free
  a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_valid || out_ready) |-> in_ready)
    else $error("in_ready low with free output register");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(out_red) && $stable(out_green) && $stable(out_blue)))
    else $error("result beat changed while stalled");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_pready)
    else $error("pready low");

endmodule

bind colormap_lerp_sampler_core cmls_checker u_cmls_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .out_red    (out_red),
  .out_green  (out_green),
  .out_blue   (out_blue),
  .cfg_pready (cfg_pready)
);

`default_nettype wire

FILE: test/tb_colormap_lerp_sampler_core.sv
`timescale 1ns / 100ps
// Self-checking bench for colormap_lerp_sampler_core: a directed stop table, then random beats.
// Needs cmls_pkg and the sampler RTL; predicts untyped samples with its own copy of the table.

module tb_colormap_lerp_sampler_core;

  localparam int HALF_PERIOD = 4;
  localparam int TABLE_DEPTH = cmls_pkg::MAX_STOPS_DEF;
  localparam int RAND_ITEMS  = 1025;
  localparam int PHASES      = 10;
  localparam int SETTLE      = 8;
  localparam int LIMIT       = 200000;
  localparam int POS_W       = cmls_pkg::POS_W;
  localparam int SEL_W       = cmls_pkg::SEL_W;
  localparam int CH_W        = cmls_pkg::CH_W;
  localparam int CNT_W       = cmls_pkg::CNT_W;
  localparam int DATA_W      = cmls_pkg::DATA_W;
  localparam int PADDR_W     = cmls_pkg::PADDR_W;
  localparam logic [PADDR_W-1:0] STOPS_ADDR =
    PADDR_W'(4 * int'(cmls_pkg::REG_STOPS_IN_USE));

  typedef enum logic {ROW_BEAT, ROW_SETUP} row_kind_t;

  typedef struct packed {
    int lo;
    int hi;
    int frac;
  } span_t;

  typedef struct {
    row_kind_t               kind;
    cmls_pkg::action_t       act;
    logic signed [POS_W-1:0] pos;
    logic [SEL_W-1:0]        sel;
    cmls_pkg::rgb_t          colour;
    bit                      typed;
    cmls_pkg::rgb_t          want;
    logic [CNT_W-1:0]        count;
  } row_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  cmls_pkg::action_t       in_action = cmls_pkg::ACT_SAMPLE;
  logic signed [POS_W-1:0] in_position = '0;
  logic [SEL_W-1:0]        in_stop_index = '0;
  logic [CH_W-1:0]         in_stop_red = '0;
  logic [CH_W-1:0]         in_stop_green = '0;
  logic [CH_W-1:0]         in_stop_blue = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b1;
  logic [CH_W-1:0]         out_red;
  logic [CH_W-1:0]         out_green;
  logic [CH_W-1:0]         out_blue;
  logic                    cfg_psel = 1'b0;
  logic                    cfg_penable = 1'b0;
  logic                    cfg_pwrite = 1'b0;
  logic [PADDR_W-1:0]      cfg_paddr = '0;
  logic [DATA_W-1:0]       cfg_pwdata = '0;
  logic [DATA_W-1:0]       cfg_prdata;
  logic                    cfg_pready;

  cmls_pkg::rgb_t          palette [TABLE_DEPTH];
  bit [TABLE_DEPTH-1:0]    palette_set = '0;
  logic [CNT_W-1:0]        stops_cfg = cmls_pkg::STOPS_RESET;
  cmls_pkg::rgb_t          pending_colours [$];
  row_t                    plan [$];
  int                      mismatches = 0;
  int                      cycles = 0;
  int                      gap_pct = 20;
  int                      stall_pct = 20;
  int                      stall_left = 0;
  bit                      calm = 1'b0;
  cmls_pkg::rgb_t          got_colour;
  cmls_pkg::rgb_t          want_colour;
  logic [CNT_W-1:0]        phase_counts [PHASES] = '{256, 2, 511, 17, 1, 300, 255, 3, 0, 64};

  colormap_lerp_sampler_core DUT (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_action, .in_position, .in_stop_index,
    .in_stop_red, .in_stop_green, .in_stop_blue,
    .out_valid, .out_ready, .out_red, .out_green, .out_blue,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_prdata, .cfg_pready
  );

  always #HALF_PERIOD clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic note_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch %s at %0t: got %0h expected %0h", what, $time, got, want);
  endtask

  // zero and counts above the table size both fold into the table
  function automatic int active_stops();
    if (stops_cfg == 0) return 1;
    if (stops_cfg > TABLE_DEPTH) return TABLE_DEPTH;
    return int'(stops_cfg);
  endfunction

  // clamp, scale by stops - 1, split into stop index and Q0.16 fraction
  function automatic span_t locate(input logic signed [POS_W-1:0] pos);
    span_t sp;
    int    n;
    int    p;
    int    scaled;
    n = active_stops();
    if (pos < 0) p = 0;
    else if (pos > 65536) p = 65536;
    else p = pos;
    scaled  = p * (n - 1);
    sp.lo   = scaled >> 16;
    sp.frac = scaled & 'hFFFF;
    sp.hi   = sp.lo + 1;
    if (sp.lo >= n - 1) begin
      sp.lo   = n - 1;
      sp.hi   = n - 1;
      sp.frac = 0;
    end
    return sp;
  endfunction

  // floor of the signed step: a falling channel rounds away from the start stop
  function automatic logic [CH_W-1:0] lerp_chan(input logic [CH_W-1:0] c1,
                                                input logic [CH_W-1:0] c2, input int frac);
    int a;
    int b;
    a = c1;
    b = c2;
    if (b >= a) return CH_W'(a + (((b - a) * frac) >> 16));
    return CH_W'(a - ((((a - b) * frac) + 65535) >> 16));
  endfunction

  function automatic cmls_pkg::rgb_t lerp_colour(input logic signed [POS_W-1:0] pos);
    span_t          sp;
    cmls_pkg::rgb_t a;
    cmls_pkg::rgb_t b;
    cmls_pkg::rgb_t c;
    sp      = locate(pos);
    a       = palette[SEL_W'(sp.lo)];
    b       = palette[SEL_W'(sp.hi)];
    c.red   = lerp_chan(a.red, b.red, sp.frac);
    c.green = lerp_chan(a.green, b.green, sp.frac);
    c.blue  = lerp_chan(a.blue, b.blue, sp.frac);
    return c;
  endfunction

  function automatic void put_beat(input cmls_pkg::action_t act, input int pos, input int sel,
                                   input logic [23:0] colour, input bit typed,
                                   input logic [23:0] want);
    row_t r;
    r.kind   = ROW_BEAT;
    r.act    = act;
    r.pos    = POS_W'(pos);
    r.sel    = SEL_W'(sel);
    r.colour = colour;
    r.typed  = typed;
    r.want   = want;
    r.count  = '0;
    plan.insert(plan.size(), r);
  endfunction

  function automatic void put_setup(input int count);
    row_t r;
    r.kind   = ROW_SETUP;
    r.act    = cmls_pkg::ACT_SAMPLE;
    r.pos    = '0;
    r.sel    = '0;
    r.colour = '0;
    r.typed  = 1'b0;
    r.want   = '0;
    r.count  = CNT_W'(count);
    plan.insert(plan.size(), r);
  endfunction

  // every task below starts and ends at a falling edge with nothing yet driven there
  task automatic send_beat(input cmls_pkg::action_t act, input logic signed [POS_W-1:0] pos,
                           input logic [SEL_W-1:0] sel, input cmls_pkg::rgb_t colour,
                           input bit typed, input cmls_pkg::rgb_t want);
    in_valid      <= 1'b1;
    in_action     <= act;
    in_position   <= pos;
    in_stop_index <= sel;
    in_stop_red   <= colour.red;
    in_stop_green <= colour.green;
    in_stop_blue  <= colour.blue;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    if (act == cmls_pkg::ACT_WRITE) begin
      palette[sel]     = colour;
      palette_set[sel] = 1'b1;
    end else begin
      pending_colours.insert(pending_colours.size(), typed ? want : lerp_colour(pos));
    end
    @(negedge clk);
  endtask

  task automatic maybe_pause(input int pct);
    if ($urandom_range(0, 99) < pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_colours.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic apb_xfer(input bit wr, input logic [DATA_W-1:0] wdata,
                          output logic [DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= STOPS_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  // change the count only once the pipe is empty and any trailing write has landed
  task automatic set_stop_count(input logic [CNT_W-1:0] count);
    logic [DATA_W-1:0] rd;
    drain();
    repeat (SETTLE) @(negedge clk);
    apb_xfer(1'b1, DATA_W'(count), rd);
    stops_cfg = count;
    apb_xfer(1'b0, '0, rd);
    if (rd !== DATA_W'(count)) note_mismatch("stops_in_use readback", rd, DATA_W'(count));
  endtask

  task automatic random_beat();
    cmls_pkg::action_t       act;
    logic signed [POS_W-1:0] pos;
    logic [SEL_W-1:0]        sel;
    cmls_pkg::rgb_t          colour;
    span_t                   sp;
    act = ($urandom_range(0, 99) < 30) ? cmls_pkg::ACT_WRITE : cmls_pkg::ACT_SAMPLE;
    case ($urandom_range(0, 9))
      0: pos = POS_W'($urandom);
      1: begin
        case ($urandom_range(0, 7))
          0: pos = 18'h20000;
          1: pos = 18'h1FFFF;
          2: pos = 18'h00000;
          3: pos = 18'h10000;
          4: pos = 18'h3FFFF;
          5: pos = 18'h0FFFF;
          6: pos = 18'h10001;
          default: pos = 18'h00001;
        endcase
      end
      default: pos = POS_W'($urandom_range(0, 65536));
    endcase
    if ($urandom_range(0, 99) < 70) sel = SEL_W'($urandom_range(0, active_stops() - 1));
    else sel = SEL_W'($urandom);
    case ($urandom_range(0, 15))
      0: colour = '0;
      1: colour = '1;
      default: colour = cmls_pkg::rgb_t'(24'($urandom));
    endcase
    // never read a stop that was not written: store the missing one instead
    if (act == cmls_pkg::ACT_SAMPLE) begin
      sp = locate(pos);
      if (!palette_set[SEL_W'(sp.lo)]) begin
        act = cmls_pkg::ACT_WRITE;
        sel = SEL_W'(sp.lo);
      end else if (!palette_set[SEL_W'(sp.hi)]) begin
        act = cmls_pkg::ACT_WRITE;
        sel = SEL_W'(sp.hi);
      end
    end
    send_beat(act, pos, sel, colour, 1'b0, '0);
  endtask

  always @(negedge clk) begin
    if (calm || !rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ready  <= 1'b0;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      got_colour = {out_red, out_green, out_blue};
      if (pending_colours.size() == 0) begin
        note_mismatch("result with no sample pending", 32'(got_colour), '0);
      end else begin
        want_colour = pending_colours.pop_front();
        if (got_colour.red !== want_colour.red)
          note_mismatch("red", 32'(got_colour.red), 32'(want_colour.red));
        if (got_colour.green !== want_colour.green)
          note_mismatch("green", 32'(got_colour.green), 32'(want_colour.green));
        if (got_colour.blue !== want_colour.blue)
          note_mismatch("blue", 32'(got_colour.blue), 32'(want_colour.blue));
      end
    end
  end

  initial begin
    // two stops under the reset count, then clamping at both ends
    put_beat(cmls_pkg::ACT_WRITE, 0, 0, 24'h00FF10, 1'b0, '0);
    put_beat(cmls_pkg::ACT_WRITE, 0, 1, 24'hFF0010, 1'b0, '0);
    put_beat(cmls_pkg::ACT_SAMPLE, 0, 0, '0, 1'b1, 24'h00FF10);
    put_beat(cmls_pkg::ACT_SAMPLE, 65536, 0, '0, 1'b1, 24'hFF0010);
    put_beat(cmls_pkg::ACT_SAMPLE, -131072, 0, '0, 1'b1, 24'h00FF10);
    put_beat(cmls_pkg::ACT_SAMPLE, 131071, 0, '0, 1'b1, 24'hFF0010);
    put_beat(cmls_pkg::ACT_SAMPLE, -1, 0, '0, 1'b1, 24'h00FF10);
    put_beat(cmls_pkg::ACT_SAMPLE, 65537, 0, '0, 1'b1, 24'hFF0010);
    put_beat(cmls_pkg::ACT_SAMPLE, 32768, 0, '0, 1'b0, '0);
    put_beat(cmls_pkg::ACT_SAMPLE, 1, 0, '0, 1'b0, '0);
    put_beat(cmls_pkg::ACT_SAMPLE, 65535, 0, '0, 1'b0, '0);
    // single stop, and a zero count folding to one
    put_setup(1);
    put_beat(cmls_pkg::ACT_SAMPLE, 65536, 0, '0, 1'b1, 24'h00FF10);
    put_beat(cmls_pkg::ACT_SAMPLE, 40000, 0, '0, 1'b1, 24'h00FF10);
    put_setup(0);
    put_beat(cmls_pkg::ACT_SAMPLE, 131071, 0, '0, 1'b1, 24'h00FF10);
    put_beat(cmls_pkg::ACT_WRITE, 0, 2, 24'h7F80FF, 1'b0, '0);
    put_setup(3);
    put_beat(cmls_pkg::ACT_SAMPLE, 65536, 0, '0, 1'b1, 24'h7F80FF);
    put_beat(cmls_pkg::ACT_SAMPLE, 32768, 0, '0, 1'b1, 24'hFF0010);
    put_beat(cmls_pkg::ACT_SAMPLE, 49152, 0, '0, 1'b0, '0);
    put_beat(cmls_pkg::ACT_WRITE, 0, 255, 24'hFFFFFF, 1'b0, '0);
    put_beat(cmls_pkg::ACT_WRITE, 0, 0, 24'h000000, 1'b0, '0);
    put_beat(cmls_pkg::ACT_SAMPLE, -65536, 0, '0, 1'b1, 24'h000000);
    put_beat(cmls_pkg::ACT_SAMPLE, 21845, 0, '0, 1'b0, '0);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_SETUP) begin
        set_stop_count(plan[i].count);
      end else begin
        maybe_pause(gap_pct);
        send_beat(plan[i].act, plan[i].pos, plan[i].sel, plan[i].colour,
                  plan[i].typed, plan[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      set_stop_count(phase_counts[ph]);
      calm      = (ph == PHASES - 1);
      gap_pct   = calm ? 0 : (ph % 3) * 15;
      stall_pct = calm ? 0 : ((ph + 1) % 3) * 15;
      for (int k = 0; k < RAND_ITEMS / PHASES; k++) begin
        // hold the sender once until the pipe has emptied
        if (ph == 1 && k == 50) drain();
        maybe_pause(gap_pct);
        random_beat();
      end
    end

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_colours.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
